[hdl/hcd_pkg.sv]
// hcd_pkg: shared types and constants for the chunked body decoder
// no dependencies; used by every other file of the block

package hcd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned START_W = 2;

  // largest body the decoder will deliver (capacity is clamped to it)
  localparam int unsigned BODY_MAX = 65536;

  localparam logic [LEN_W-1:0] CAPACITY_RST = 17'h10000;

  // decoder phases
  localparam logic [PHASE_W-1:0] PH_SIZE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LF     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DATA   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TRAIL1 = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TRAIL2 = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;

  // size line progress
  localparam logic [START_W-1:0] SS_BLANK   = 2'd0;
  localparam logic [START_W-1:0] SS_DIGITS  = 2'd1;
  localparam logic [START_W-1:0] SS_STOPPED = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_LA    = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LF_HEX = 8'h66;
  localparam logic [BYTE_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UF    = 8'h46;

  typedef struct packed {
    logic       is_blank;
    logic       is_digit;
    logic [3:0] digit;
  } char_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              done_res;
    logic [LEN_W-1:0]  body_length;
  } result_t;

endpackage

[hdl/hcd_if.sv]
// hcd_if: request channels of the chunked body decoder (input, result, config)
// depends on hcd_pkg for field widths

interface hcd_in_if;
  logic                           valid;
  logic                           ready;
  logic [hcd_pkg::BYTE_W-1:0]     in_byte;
  logic                           stream_end;

  modport source (output valid, in_byte, stream_end, input ready);
  modport sink (input valid, in_byte, stream_end, output ready);
endinterface

interface hcd_out_if;
  logic                           valid;
  logic                           ready;
  logic [hcd_pkg::BYTE_W-1:0]     out_byte;
  logic                           out_valid;
  logic                           done_res;
  logic [hcd_pkg::LEN_W-1:0]      body_length;

  modport source (output valid, out_byte, out_valid, done_res, body_length, input ready);
  modport sink (input valid, out_byte, out_valid, done_res, body_length, output ready);
endinterface

interface hcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hcd_pkg::LEN_W-1:0]      capacity;

  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface

[hdl/hcd_char_class.sv]
// hcd_char_class: sorts one body byte into blank, hex digit or other
// depends on hcd_pkg (char_t and character codes)

module hcd_char_class (
  input  logic [hcd_pkg::BYTE_W-1:0] byte_i,
  output hcd_pkg::char_t             class_o
);

  logic is_dec, is_low, is_up;
  logic [hcd_pkg::BYTE_W-1:0] off;

  assign is_dec = (byte_i >= hcd_pkg::CHAR_0) && (byte_i <= hcd_pkg::CHAR_9);
  assign is_low = (byte_i >= hcd_pkg::CHAR_LA) && (byte_i <= hcd_pkg::CHAR_LF_HEX);
  assign is_up  = (byte_i >= hcd_pkg::CHAR_UA) && (byte_i <= hcd_pkg::CHAR_UF);

  always_comb begin
    if (is_dec) begin
      off = byte_i - hcd_pkg::CHAR_0;
    end else if (is_low) begin
      off = byte_i - hcd_pkg::CHAR_LA + 8'd10;
    end else if (is_up) begin
      off = byte_i - hcd_pkg::CHAR_UA + 8'd10;
    end else begin
      off = '0;
    end
  end

  assign class_o.is_digit = is_dec || is_low || is_up;
  assign class_o.digit    = off[3:0];
  assign class_o.is_blank = (byte_i == hcd_pkg::CHAR_SPACE) || (byte_i == hcd_pkg::CHAR_TAB) ||
                            (byte_i == hcd_pkg::CHAR_LF) || (byte_i == hcd_pkg::CHAR_VT) ||
                            (byte_i == hcd_pkg::CHAR_FF);

endmodule

[hdl/hcd_engine.sv]
// hcd_engine: input register, framing state and the per-byte state update
// depends on hcd_pkg and hcd_char_class

module hcd_engine #(
  parameter int unsigned SIZE_LINE_MAX = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [hcd_pkg::BYTE_W-1:0]  in_byte_i,
  input  logic                        stream_end_i,
  output logic                        in_ready_o,
  input  logic [hcd_pkg::LEN_W-1:0]   capacity_i,
  input  logic                        take_i,
  output logic                        res_valid_o,
  output hcd_pkg::result_t            res_o
);

  localparam int unsigned CW = hcd_pkg::LEN_W;
  localparam int unsigned SW = $clog2(hcd_pkg::BODY_MAX + 1);
  localparam int unsigned LW = $clog2(SIZE_LINE_MAX + 1);
  localparam int unsigned MW = (SW > CW) ? SW : CW;

  // input register
  logic                        s1_valid_q;
  logic [hcd_pkg::BYTE_W-1:0]  s1_byte_q;
  logic                        s1_end_q;
  logic                        step;

  // framing state
  logic [hcd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [SW-1:0]               size_value_q, size_value_d;
  logic [hcd_pkg::START_W-1:0] started_q, started_d;
  logic [LW-1:0]               line_count_q, line_count_d;
  logic [CW-1:0]               chunk_left_q, chunk_left_d;
  logic [CW-1:0]               delivered_q, delivered_d;

  hcd_pkg::char_t              cc;
  logic [CW-1:0]               eff_cap;
  logic                        cap_hit;
  logic [CW-1:0]               room;
  logic [SW+3:0]               acc;
  logic [SW-1:0]               acc_sat;
  logic [SW-1:0]               line_val;
  logic [hcd_pkg::START_W-1:0] line_started;
  logic [LW-1:0]               line_cnt_inc;
  logic [SW-1:0]               end_sz;
  logic                        end_done;
  logic [CW-1:0]               end_chunk;
  logic                        out_valid;

  assign step       = s1_valid_q && take_i;
  assign in_ready_o = !s1_valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
      s1_end_q  <= stream_end_i;
    end
  end

  hcd_char_class u_char_class (
    .byte_i  (s1_byte_q),
    .class_o (cc)
  );

  assign eff_cap = (32'(capacity_i) > 32'(hcd_pkg::BODY_MAX)) ? CW'(hcd_pkg::BODY_MAX) :
                   capacity_i;
  assign cap_hit = delivered_q >= eff_cap;
  assign room    = cap_hit ? '0 : eff_cap - delivered_q;

  // hex accumulate with saturation at the body limit
  assign acc     = {size_value_q, cc.digit};
  assign acc_sat = (acc > (SW+4)'(hcd_pkg::BODY_MAX)) ? SW'(hcd_pkg::BODY_MAX) : acc[SW-1:0];

  always_comb begin
    line_val     = size_value_q;
    line_started = started_q;
    if ((started_q == hcd_pkg::SS_BLANK) && cc.is_blank) begin
      line_started = started_q;
    end else if ((started_q != hcd_pkg::SS_STOPPED) && cc.is_digit) begin
      line_started = hcd_pkg::SS_DIGITS;
      line_val     = acc_sat;
    end else begin
      line_started = hcd_pkg::SS_STOPPED;
    end
  end

  assign line_cnt_inc = line_count_q + LW'(1);

  // end of size line: zero size or no room left finishes decoding
  assign end_sz    = (phase_q == hcd_pkg::PH_LF) ? size_value_q : line_val;
  assign end_done  = (end_sz == '0) || (room == '0);
  assign end_chunk = (MW'(end_sz) > MW'(room)) ? room : CW'(end_sz);

  always_comb begin
    phase_d      = phase_q;
    size_value_d = size_value_q;
    started_d    = started_q;
    line_count_d = line_count_q;
    chunk_left_d = chunk_left_q;
    delivered_d  = delivered_q;
    out_valid    = 1'b0;
    if (phase_q != hcd_pkg::PH_DONE) begin
      if ((phase_q == hcd_pkg::PH_SIZE) && (line_count_q == '0) &&
          (started_q == hcd_pkg::SS_BLANK) && cap_hit) begin
        phase_d = hcd_pkg::PH_DONE;
      end else if (s1_end_q) begin
        phase_d = hcd_pkg::PH_DONE;
      end else begin
        case (phase_q)
          hcd_pkg::PH_SIZE: begin
            if (s1_byte_q == hcd_pkg::CHAR_CR) begin
              phase_d = hcd_pkg::PH_LF;
            end else if (line_cnt_inc >= LW'(SIZE_LINE_MAX)) begin
              size_value_d = '0;
              started_d    = hcd_pkg::SS_BLANK;
              line_count_d = '0;
              phase_d      = end_done ? hcd_pkg::PH_DONE : hcd_pkg::PH_DATA;
              chunk_left_d = end_done ? chunk_left_q : end_chunk;
            end else begin
              size_value_d = line_val;
              started_d    = line_started;
              line_count_d = line_cnt_inc;
            end
          end
          hcd_pkg::PH_LF: begin
            size_value_d = '0;
            started_d    = hcd_pkg::SS_BLANK;
            line_count_d = '0;
            phase_d      = end_done ? hcd_pkg::PH_DONE : hcd_pkg::PH_DATA;
            chunk_left_d = end_done ? chunk_left_q : end_chunk;
          end
          hcd_pkg::PH_DATA: begin
            out_valid    = 1'b1;
            delivered_d  = delivered_q + CW'(1);
            chunk_left_d = chunk_left_q - CW'(1);
            if (chunk_left_q == CW'(1)) begin
              phase_d = hcd_pkg::PH_TRAIL1;
            end
          end
          hcd_pkg::PH_TRAIL1: begin
            phase_d = hcd_pkg::PH_TRAIL2;
          end
          hcd_pkg::PH_TRAIL2: begin
            size_value_d = '0;
            started_d    = hcd_pkg::SS_BLANK;
            line_count_d = '0;
            phase_d      = cap_hit ? hcd_pkg::PH_DONE : hcd_pkg::PH_SIZE;
          end
          default: begin
            phase_d = hcd_pkg::PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= hcd_pkg::PH_SIZE;
      size_value_q <= '0;
      started_q    <= hcd_pkg::SS_BLANK;
      line_count_q <= '0;
      chunk_left_q <= '0;
      delivered_q  <= '0;
    end else if (step) begin
      phase_q      <= phase_d;
      size_value_q <= size_value_d;
      started_q    <= started_d;
      line_count_q <= line_count_d;
      chunk_left_q <= chunk_left_d;
      delivered_q  <= delivered_d;
    end
  end

  assign res_valid_o       = step;
  assign res_o.out_byte    = out_valid ? s1_byte_q : '0;
  assign res_o.out_valid   = out_valid;
  assign res_o.done_res    = (phase_d == hcd_pkg::PH_DONE);
  assign res_o.body_length = delivered_d;

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hcd_pkg::PH_DONE |=> phase_q == hcd_pkg::PH_DONE)
    else $error("decoder left the done phase");

  a_count_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step && phase_q == hcd_pkg::PH_DATA) |=> $stable(delivered_q))
    else $error("delivered count moved outside a payload byte");

  a_chunk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == hcd_pkg::PH_DATA |-> chunk_left_q != '0)
    else $error("payload phase with nothing left in the chunk");

  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_count_q < LW'(SIZE_LINE_MAX))
    else $error("size line count passed its limit");

endmodule

[hdl/http_chunked_body_decoder.sv]
// http_chunked_body_decoder: top level, capacity register and result register
// depends on hcd_pkg, hcd_if and hcd_engine
//
// Strips chunk framing from a response body that arrives one byte per request,
// giving one result per input byte: the payload byte when it is one, the done
// flag and the running body length. Throughput is one byte per clock while the
// result side keeps up; a byte passes the input register and then the result
// register on its way out, and the framing state is updated once per byte in a
// single pass. Capacity should only be written while no byte is
// in flight. There is no clearing pass after reset.

module http_chunked_body_decoder #(
  parameter int unsigned SIZE_LINE_MAX = 31
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcd_in_if.sink    body_in,
  hcd_out_if.source body_out,
  hcd_cfg_if.sink   cfg
);

  logic [hcd_pkg::LEN_W-1:0] capacity_q;
  logic                      out_valid_q;
  hcd_pkg::result_t          res_q;
  hcd_pkg::result_t          res;
  logic                      res_valid;
  logic                      take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= hcd_pkg::CAPACITY_RST;
    end else if (cfg.valid) begin
      capacity_q <= cfg.capacity;
    end
  end

  // output stage is free when empty or being drained this cycle
  assign take = !out_valid_q || body_out.ready;

  hcd_engine #(
    .SIZE_LINE_MAX (SIZE_LINE_MAX)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (body_in.valid),
    .in_byte_i    (body_in.in_byte),
    .stream_end_i (body_in.stream_end),
    .in_ready_o   (body_in.ready),
    .capacity_i   (capacity_q),
    .take_i       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign body_out.valid       = out_valid_q;
  assign body_out.out_byte    = res_q.out_byte;
  assign body_out.out_valid   = res_q.out_valid;
  assign body_out.done_res    = res_q.done_res;
  assign body_out.body_length = res_q.body_length;

  a_payload_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.out_valid |-> !res_q.done_res)
    else $error("payload byte reported together with done");

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for http_chunked_body_decoder, one result per input byte
// depends on hcd_pkg and the interfaces in hcd_if; an in-bench decoder model gives the
// expected results, and each result is compared field by field as it is accepted

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX        = 31;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // longest correct stretch with no request is the receiver hold-off
  localparam int unsigned STALL_LIMIT     = 4000;

  localparam logic [hcd_pkg::BYTE_W-1:0] CHAR_SEMI = 8'h3B;
  localparam logic [hcd_pkg::BYTE_W-1:0] CHAR_LG   = 8'h67;
  localparam logic [4:0][hcd_pkg::BYTE_W-1:0] BLANKS = {
    hcd_pkg::CHAR_SPACE, hcd_pkg::CHAR_TAB, hcd_pkg::CHAR_LF, hcd_pkg::CHAR_VT,
    hcd_pkg::CHAR_FF};
  localparam hcd_pkg::result_t NO_RES = '0;

  typedef enum int {
    END_CUT,
    END_CAP_MID_CHUNK,
    END_STREAM,
    END_ZERO_SIZE,
    END_CAP_LINE_START
  } end_case_e;

  typedef struct packed {
    logic [hcd_pkg::BYTE_W-1:0] data;
    logic                       eos;
    logic                       typed;
    hcd_pkg::result_t           res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  hcd_in_if  body_in_ch ();
  hcd_out_if body_out_ch ();
  hcd_cfg_if cfg_ch ();

  http_chunked_body_decoder #(
    .SIZE_LINE_MAX (LINE_MAX)
  ) dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .body_in  (body_in_ch),
    .body_out (body_out_ch),
    .cfg      (cfg_ch)
  );

  // decoder model state
  logic [hcd_pkg::PHASE_W-1:0] dec_phase  = hcd_pkg::PH_SIZE;
  logic [hcd_pkg::START_W-1:0] size_state = hcd_pkg::SS_BLANK;
  int unsigned                 size_acc   = 0;
  int unsigned                 line_bytes = 0;
  int unsigned                 chunk_rem  = 0;
  int unsigned                 dlv_count  = 0;
  logic [hcd_pkg::LEN_W-1:0]   cap_reg    = hcd_pkg::CAPACITY_RST;

  hcd_pkg::result_t decoded_q[$];
  int unsigned mismatches = 0;
  int unsigned sent_bytes = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_off_req = 1'b0;

  // walk of the opening: every blank, a digit, a stray byte taken as LF, a stopped size
  // line and both byte extremes as payload
  stim_row_t dir_rows [0:19] = '{
    '{hcd_pkg::CHAR_SPACE, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 17'd0}},
    '{hcd_pkg::CHAR_TAB,   1'b0, 1'b0, NO_RES},
    '{hcd_pkg::CHAR_LF,    1'b0, 1'b0, NO_RES},
    '{hcd_pkg::CHAR_VT,    1'b0, 1'b0, NO_RES},
    '{hcd_pkg::CHAR_FF,    1'b0, 1'b0, NO_RES},
    '{8'h31,               1'b0, 1'b0, NO_RES},
    '{hcd_pkg::CHAR_CR,    1'b0, 1'b0, NO_RES},
    '{hcd_pkg::CHAR_LF,    1'b0, 1'b0, NO_RES},
    '{8'hFF,               1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 17'd1}},
    '{hcd_pkg::CHAR_CR,    1'b0, 1'b0, NO_RES},
    '{hcd_pkg::CHAR_LF,    1'b0, 1'b0, NO_RES},
    '{8'h32,               1'b0, 1'b0, NO_RES},
    '{CHAR_LG,             1'b0, 1'b0, NO_RES},
    '{CHAR_SEMI,           1'b0, 1'b0, NO_RES},
    '{hcd_pkg::CHAR_CR,    1'b0, 1'b0, NO_RES},
    '{8'h00,               1'b0, 1'b0, NO_RES},
    '{8'h00,               1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 17'd2}},
    '{8'h80,               1'b0, 1'b1, '{8'h80, 1'b1, 1'b0, 17'd3}},
    '{hcd_pkg::CHAR_CR,    1'b0, 1'b0, NO_RES},
    '{hcd_pkg::CHAR_LF,    1'b0, 1'b0, NO_RES}
  };

  function automatic logic [hcd_pkg::BYTE_W-1:0] byte_of(input int unsigned v);
    logic [31:0] w;
    w = v;
    return w[hcd_pkg::BYTE_W-1:0];
  endfunction

  function automatic logic [hcd_pkg::LEN_W-1:0] cap_of(input int unsigned v);
    logic [31:0] w;
    w = v;
    return w[hcd_pkg::LEN_W-1:0];
  endfunction

  function automatic logic [hcd_pkg::BYTE_W-1:0] rand_byte();
    return byte_of($urandom_range(255));
  endfunction

  function automatic logic [hcd_pkg::BYTE_W-1:0] rand_blank();
    logic [2:0] k;
    k = 3'($urandom_range(4));
    return BLANKS[k];
  endfunction

  function automatic int unsigned cap_limit();
    int unsigned c;
    c = {15'd0, cap_reg};
    return (c > hcd_pkg::BODY_MAX) ? hcd_pkg::BODY_MAX : c;
  endfunction

  function automatic void close_size_line();
    int unsigned room;
    int unsigned sz;
    room = (dlv_count < cap_limit()) ? cap_limit() - dlv_count : 0;
    sz = (size_acc > room) ? room : size_acc;
    size_acc   = 0;
    size_state = hcd_pkg::SS_BLANK;
    line_bytes = 0;
    if (sz == 0) begin
      dec_phase = hcd_pkg::PH_DONE;
    end else begin
      chunk_rem = sz;
      dec_phase = hcd_pkg::PH_DATA;
    end
  endfunction

  function automatic hcd_pkg::result_t decode_byte(logic [hcd_pkg::BYTE_W-1:0] b, logic eos);
    hcd_pkg::result_t r;
    int               d;
    logic             is_blank;
    r = '0;
    if (dec_phase != hcd_pkg::PH_DONE) begin
      if (dec_phase == hcd_pkg::PH_SIZE && line_bytes == 0 &&
          size_state == hcd_pkg::SS_BLANK && dlv_count >= cap_limit()) begin
        dec_phase = hcd_pkg::PH_DONE;
      end else if (eos) begin
        dec_phase = hcd_pkg::PH_DONE;
      end else begin
        case (dec_phase)
          hcd_pkg::PH_SIZE: begin
            if (b == hcd_pkg::CHAR_CR) begin
              dec_phase = hcd_pkg::PH_LF;
            end else begin
              d = -1;
              if (b >= hcd_pkg::CHAR_0 && b <= hcd_pkg::CHAR_9)
                d = int'(b - hcd_pkg::CHAR_0);
              else if (b >= hcd_pkg::CHAR_LA && b <= hcd_pkg::CHAR_LF_HEX)
                d = int'(b - hcd_pkg::CHAR_LA) + 10;
              else if (b >= hcd_pkg::CHAR_UA && b <= hcd_pkg::CHAR_UF)
                d = int'(b - hcd_pkg::CHAR_UA) + 10;
              is_blank = b inside {hcd_pkg::CHAR_SPACE, hcd_pkg::CHAR_TAB, hcd_pkg::CHAR_LF,
                                   hcd_pkg::CHAR_VT, hcd_pkg::CHAR_FF};
              if (!(size_state == hcd_pkg::SS_BLANK && is_blank)) begin
                if (size_state != hcd_pkg::SS_STOPPED && d >= 0) begin
                  size_state = hcd_pkg::SS_DIGITS;
                  size_acc   = size_acc * 16 + d;
                  if (size_acc > hcd_pkg::BODY_MAX) size_acc = hcd_pkg::BODY_MAX;
                end else begin
                  size_state = hcd_pkg::SS_STOPPED;
                end
              end
              line_bytes++;
              // an over-long line closes without a CR
              if (line_bytes >= LINE_MAX) close_size_line();
            end
          end
          hcd_pkg::PH_LF: begin
            close_size_line();
          end
          hcd_pkg::PH_DATA: begin
            r.out_byte  = b;
            r.out_valid = 1'b1;
            dlv_count++;
            if (chunk_rem > 0) chunk_rem--;
            if (chunk_rem == 0) dec_phase = hcd_pkg::PH_TRAIL1;
          end
          hcd_pkg::PH_TRAIL1: begin
            dec_phase = hcd_pkg::PH_TRAIL2;
          end
          default: begin
            dec_phase  = hcd_pkg::PH_SIZE;
            size_acc   = 0;
            size_state = hcd_pkg::SS_BLANK;
            line_bytes = 0;
            if (dlv_count >= cap_limit()) dec_phase = hcd_pkg::PH_DONE;
          end
        endcase
      end
    end
    r.done_res    = (dec_phase == hcd_pkg::PH_DONE);
    r.body_length = dlv_count[hcd_pkg::LEN_W-1:0];
    return r;
  endfunction

  task automatic send_byte(input logic [hcd_pkg::BYTE_W-1:0] b, input logic eos,
                           input logic typed = 1'b0,
                           input hcd_pkg::result_t typed_res = '0);
    hcd_pkg::result_t r;
    r = decode_byte(b, eos);
    decoded_q.push_back(typed ? typed_res : r);
    sent_bytes++;
    if ($urandom_range(99) < tx_idle_pct) begin
      body_in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    body_in_ch.valid      <= 1'b1;
    body_in_ch.in_byte    <= b;
    body_in_ch.stream_end <= eos;
    do @(posedge clk); while (!(body_in_ch.valid && body_in_ch.ready));
  endtask

  task automatic drain();
    body_in_ch.valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
  endtask

  // every byte gives a result, so an empty queue means nothing is in flight
  task automatic write_capacity(input logic [hcd_pkg::LEN_W-1:0] value);
    drain();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    cap_reg = value;
  endtask

  task automatic send_chunk(input int unsigned len, input bit noisy);
    logic [hcd_pkg::BYTE_W-1:0] line_q[$];
    logic [hcd_pkg::BYTE_W-1:0] digits_q[$];
    logic [hcd_pkg::BYTE_W-1:0] pad;
    int unsigned                v;
    int unsigned                d;
    int unsigned                pad_to;
    bit                         long_line;
    long_line = noisy && ($urandom_range(2) == 0);
    repeat ($urandom_range(2)) line_q.push_back(rand_blank());
    repeat ($urandom_range(2)) line_q.push_back(hcd_pkg::CHAR_0);
    v = len;
    do begin
      d = v % 16;
      if (d < 10) digits_q.push_front(byte_of(hcd_pkg::CHAR_0 + d));
      else digits_q.push_front(byte_of(($urandom_range(1) ? hcd_pkg::CHAR_LA : hcd_pkg::CHAR_UA)
                                       + d - 10));
      v = v / 16;
    end while (v != 0);
    line_q = {line_q, digits_q};
    if (long_line || (noisy && $urandom_range(1) == 1)) begin
      // chunk extension: the first non-hex byte stops the size
      line_q.push_back(CHAR_SEMI);
      pad_to = long_line ? LINE_MAX : 8 + $urandom_range(5);
      while (line_q.size() < pad_to) begin
        pad = rand_byte();
        line_q.push_back((pad == hcd_pkg::CHAR_CR) ? CHAR_SEMI : pad);
      end
    end
    foreach (line_q[i]) send_byte(line_q[i], 1'b0);
    if (!long_line) begin
      send_byte(hcd_pkg::CHAR_CR, 1'b0);
      send_byte((noisy && $urandom_range(1) == 1) ? rand_byte() : hcd_pkg::CHAR_LF, 1'b0);
    end
    repeat (len) send_byte(rand_byte(), 1'b0);
    if (noisy) begin
      repeat (2) send_byte(rand_byte(), 1'b0);
    end else begin
      send_byte(hcd_pkg::CHAR_CR, 1'b0);
      send_byte(hcd_pkg::CHAR_LF, 1'b0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    body_out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        body_out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        body_out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    hcd_pkg::result_t got;
    hcd_pkg::result_t want;
    if (rst_n && body_out_ch.valid && body_out_ch.ready) begin
      got.out_byte    = body_out_ch.out_byte;
      got.out_valid   = body_out_ch.out_valid;
      got.done_res    = body_out_ch.done_res;
      got.body_length = body_out_ch.body_length;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h valid %0d done %0d len %0d",
                   got.out_byte, got.out_valid, got.done_res, got.body_length);
      end else begin
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
            got.done_res !== want.done_res || got.body_length !== want.body_length) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected byte %02h valid %0d done %0d len %0d,",
                      " got byte %02h valid %0d done %0d len %0d"},
                     want.out_byte, want.out_valid, want.done_res, want.body_length,
                     got.out_byte, got.out_valid, got.done_res, got.body_length);
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((body_in_ch.valid && body_in_ch.ready) || (body_out_ch.valid && body_out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("[http_chunked_body_decoder] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned target;
    int unsigned len;
    end_case_e   ending;
    rst_n                 <= 1'b0;
    body_in_ch.valid      <= 1'b0;
    body_in_ch.in_byte    <= '0;
    body_in_ch.stream_end <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.capacity       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].eos,
                                    dir_rows[i].typed, dir_rows[i].res);

    // random streams, mostly well formed, capacity kept out of reach
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       write_capacity(17'h1FFFF);
        1:       write_capacity(hcd_pkg::CAPACITY_RST);
        2:       write_capacity(cap_of($urandom_range(20000, 65535)));
        3:       write_capacity(cap_of(32'h10000 + $urandom_range(1, 32'hFFFF)));
        default: write_capacity(cap_of($urandom_range(32768, 65536)));
      endcase
      tx_idle_pct  = (ph % 4 == 1) ? 45 : (ph % 4 == 3) ? 23 : 0;
      rx_stall_pct = (ph % 4 == 2) ? 45 : (ph % 4 == 3) ? 23 : 0;
      if (ph == 2) hold_off_req = 1'b1;
      target = sent_bytes + 120;
      while (sent_bytes < target) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_chunk(len, $urandom_range(3) == 0);
      end
    end

    // decoding stops for good, so only one way of ending fits in a run
    tx_idle_pct  = 23;
    rx_stall_pct = 23;
    ending = end_case_e'($urandom_range(4));
    case (ending)
      END_CUT: begin
        // saturated size, cut to the room left
        write_capacity(cap_of(dlv_count + $urandom_range(1, 6)));
        repeat (6) send_byte(hcd_pkg::CHAR_UF, 1'b0);
        send_byte(hcd_pkg::CHAR_CR, 1'b0);
        send_byte(hcd_pkg::CHAR_LF, 1'b0);
        repeat (8) send_byte(rand_byte(), 1'b0);
      end
      END_CAP_MID_CHUNK: begin
        send_byte(byte_of(hcd_pkg::CHAR_0 + 4), 1'b0);
        send_byte(hcd_pkg::CHAR_CR, 1'b0);
        send_byte(hcd_pkg::CHAR_LF, 1'b0);
        repeat (2) send_byte(rand_byte(), 1'b0);
        write_capacity(cap_of($urandom_range(1)));
        repeat (2) send_byte(rand_byte(), 1'b0);
        send_byte(hcd_pkg::CHAR_CR, 1'b0);
        send_byte(hcd_pkg::CHAR_LF, 1'b0);
        send_byte(rand_byte(), 1'b0);
      end
      END_STREAM: begin
        send_byte(byte_of(hcd_pkg::CHAR_0 + 8), 1'b0);
        send_byte(hcd_pkg::CHAR_CR, 1'b0);
        send_byte(hcd_pkg::CHAR_LF, 1'b0);
        repeat (3) send_byte(rand_byte(), 1'b0);
        send_byte(rand_byte(), 1'b1);
      end
      END_ZERO_SIZE: begin
        send_byte(rand_blank(), 1'b0);
        send_byte($urandom_range(1) ? hcd_pkg::CHAR_0 : CHAR_SEMI, 1'b0);
        send_byte(hcd_pkg::CHAR_CR, 1'b0);
        send_byte(hcd_pkg::CHAR_LF, 1'b0);
      end
      default: begin
        write_capacity(cap_of(dlv_count));
        send_byte(rand_byte(), 1'b0);
      end
    endcase

    // after the end every byte is ignored
    write_capacity('0);
    repeat (20) send_byte(rand_byte(), $urandom_range(1) == 1);
    write_capacity(17'd1);
    repeat (20) send_byte(rand_byte(), $urandom_range(1) == 1);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("[http_chunked_body_decoder] OK");
    end else begin
      $display("[http_chunked_body_decoder] ERROR");
    end
    $finish;
  end

endmodule
